// ===== design/sapp_pkg.sv =====
// Shared types and constants for the SOCKS address and port parser.
package sapp_pkg;

   // Address-type codes as they appear on the wire
   localparam logic [7:0] TYPE_CODE_IPV4   = 8'd1;
   localparam logic [7:0] TYPE_CODE_DOMAIN = 8'd3;
   localparam logic [7:0] TYPE_CODE_IPV6   = 8'd4;

   // Address lengths for the fixed-size types
   localparam logic [7:0] IPV4_ADDR_LEN = 8'd4;
   localparam logic [7:0] IPV6_ADDR_LEN = 8'd16;

   // Longest header: type, length byte, 255 name bytes, two port bytes
   localparam logic [8:0] MAX_HEADER_LEN = 9'd259;

   // Default depth of the queue between parser and result stage
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      ST_SUCCESS     = 2'd0,
      ST_BAD         = 2'd1,
      ST_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ATYPE_IPV4   = 2'd0,
      ATYPE_DOMAIN = 2'd1,
      ATYPE_IPV6   = 2'd2
   } atype_type;

   typedef enum logic [2:0] {
      PH_TYPE    = 3'd0,
      PH_DLEN    = 3'd1,
      PH_ADDR    = 3'd2,
      PH_PORT_HI = 3'd3,
      PH_PORT_LO = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   // Work for the result stage: up to one address byte, then up to one summary
   typedef struct packed {
      logic       has_byte;
      logic [7:0] addr_byte;
      logic       has_summary;
      logic [1:0] status;
      logic [1:0] atype;
      logic [7:0] dlen;
      logic [15:0] port;
      logic [8:0] hlen;
   } cmd_type;

endpackage

// ===== design/socks_address_port_parser_unit.sv =====
// Top level of the SOCKS address and port parser.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+---------------------------------------
//  req      | in  | req_tvalid / req_tready  | tdata: data_byte; tlast: last;
//           |     |                          | tuser: empty_buffer
//  rsp      | out | rsp_tvalid / rsp_tready  | tdata: address/summary fields;
//           |     |                          | tlast: end_of_run; tuser: kind
//
// One request transaction per cycle while the queue is not full; the parser updates its state in the cycle
// the byte is accepted. A byte that yields both an address byte and a summary
// costs the result stage two transactions; the work queue (QueueDepth entries) absorbs that.
// A request's work passes through the queue and then the output register before its response.
// Synchronous active-high reset returns the parser to the type byte and empties the queue.
// Either side may stall independently; req_tready drops only when the queue is full.
module socks_address_port_parser_unit
   import sapp_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] empty_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] address_byte, [9:8] status, [11:10] address_type,
   // [19:12] domain_length, [35:20] port, [44:36] header_length, [47:45] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,   // end_of_run
   output logic        rsp_tuser    // [0] kind
);

   cmd_type     push_cmd;
   cmd_type     pop_cmd;
   logic        q_push, q_full, q_pop, q_not_empty;
   logic [7:0]  addr_byte;
   logic [1:0]  status;
   logic [1:0]  atype;
   logic [7:0]  dlen;
   logic [15:0] port;
   logic [8:0]  hlen;

   // Front: parses accepted bytes and queues the result work they yield
   sapp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   sapp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   // Back: emits address byte and/or summary transactions
   sapp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_cmd         (pop_cmd),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_kind      (rsp_tuser),
      .rsp_addr_byte (addr_byte),
      .rsp_status    (status),
      .rsp_atype     (atype),
      .rsp_dlen      (dlen),
      .rsp_port      (port),
      .rsp_hlen      (hlen),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, hlen, port, dlen, atype, status, addr_byte};

endmodule

// ===== design/sapp_front.sv =====
// Parser front end: accepts buffer bytes and turns them into result work.
module sapp_front
   import sapp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       req_tuser,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  type_ff, type_in;
   logic [7:0]  remain_ff, remain_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [7:0]  port_hi_ff, port_hi_in;
   logic [8:0]  count_ff, count_in;

   logic        fire;
   logic        ends;
   logic [7:0]  remain_dec;
   logic [8:0]  count_inc;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;
   assign ends       = req_tlast || req_tuser;
   assign remain_dec = remain_ff - 8'd1;
   assign count_inc  = count_ff + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         type_ff    <= '0;
         remain_ff  <= '0;
         dlen_ff    <= '0;
         port_hi_ff <= '0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         type_ff    <= type_in;
         remain_ff  <= remain_in;
         dlen_ff    <= dlen_in;
         port_hi_ff <= port_hi_in;
         count_ff   <= count_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      type_in    = type_ff;
      remain_in  = remain_ff;
      dlen_in    = dlen_ff;
      port_hi_in = port_hi_ff;
      count_in   = count_ff;
      q_cmd      = '0;

      if (fire && !req_tuser) begin
         unique case (phase_ff)
            PH_TYPE: begin
               count_in  = 9'd1;
               dlen_in   = '0;
               remain_in = '0;
               priority if (req_tdata == TYPE_CODE_IPV4) begin
                  type_in   = ATYPE_IPV4;
                  remain_in = IPV4_ADDR_LEN;
                  phase_in  = PH_ADDR;
               end else if (req_tdata == TYPE_CODE_DOMAIN) begin
                  type_in  = ATYPE_DOMAIN;
                  phase_in = PH_DLEN;
               end else if (req_tdata == TYPE_CODE_IPV6) begin
                  type_in   = ATYPE_IPV6;
                  remain_in = IPV6_ADDR_LEN;
                  phase_in  = PH_ADDR;
               end else begin
                  q_cmd.has_summary = 1'b1;
                  q_cmd.status      = ST_UNSUPPORTED;
                  phase_in          = PH_DONE;
               end
            end
            PH_DLEN: begin
               dlen_in   = req_tdata;
               remain_in = req_tdata;
               count_in  = count_inc;
               phase_in  = (req_tdata != 8'd0) ? PH_ADDR : PH_PORT_HI;
            end
            PH_ADDR: begin
               q_cmd.has_byte  = 1'b1;
               q_cmd.addr_byte = req_tdata;
               count_in        = count_inc;
               remain_in       = remain_dec;
               if (remain_dec == 8'd0) begin
                  phase_in = PH_PORT_HI;
               end
            end
            PH_PORT_HI: begin
               port_hi_in = req_tdata;
               count_in   = count_inc;
               phase_in   = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               count_in          = count_inc;
               q_cmd.has_summary = 1'b1;
               q_cmd.status      = ST_SUCCESS;
               q_cmd.atype       = type_ff;
               q_cmd.dlen        = (type_ff == ATYPE_DOMAIN) ? dlen_ff : 8'd0;
               q_cmd.port        = {port_hi_ff, req_tdata};
               q_cmd.hlen        = count_inc;
               phase_in          = PH_DONE;
            end
            default: begin
               // trailing bytes after the header: nothing to do
            end
         endcase
      end

      // End of buffer: short header is a bad message, then rearm
      if (fire && ends) begin
         if (phase_in != PH_DONE) begin
            q_cmd.has_summary = 1'b1;
            q_cmd.status      = ST_BAD;
         end
         phase_in   = PH_TYPE;
         type_in    = '0;
         remain_in  = '0;
         dlen_in    = '0;
         port_hi_in = '0;
         count_in   = '0;
      end
   end

   assign q_push = fire && (q_cmd.has_byte || q_cmd.has_summary);

   a_addr_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ADDR |-> remain_ff != 8'd0)
      else $error("address phase with nothing left to read");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      fire && ends |=> phase_ff == PH_TYPE && count_ff == 9'd0)
      else $error("parser did not rearm at end of buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_HEADER_LEN)
      else $error("header byte count out of range");

endmodule

// ===== design/sapp_queue.sv =====
// Small queue of result work between the parser and the result stage.
module sapp_queue
   import sapp_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_cmd
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   cmd_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == DepthCnt);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue occupancy beyond depth");

endmodule

// ===== design/sapp_back.sv =====
// Result stage: plays out each queued work entry as one or two transactions.
module sapp_back
   import sapp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_addr_byte,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_atype,
   output logic [7:0]  rsp_dlen,
   output logic [15:0] rsp_port,
   output logic [8:0]  rsp_hlen,
   output logic        rsp_last
);

   logic    valid_ff, valid_in;
   cmd_type cur_ff, cur_in;
   logic    fire;
   logic    finishing;

   assign fire      = valid_ff && rsp_tready;
   // Entry is finished once its final transaction goes out
   assign finishing = fire && !(cur_ff.has_byte && cur_ff.has_summary);
   assign q_pop     = q_not_empty && (!valid_ff || finishing);

   always_comb begin
      valid_in = valid_ff;
      cur_in   = cur_ff;
      priority if (q_pop) begin
         valid_in = 1'b1;
         cur_in   = q_cmd;
      end else if (finishing) begin
         valid_in = 1'b0;
      end else if (fire) begin
         cur_in.has_byte = 1'b0;   // byte sent, summary still owed
      end else begin
         // idle or stalled: hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_kind      = !cur_ff.has_byte;
   assign rsp_addr_byte = cur_ff.has_byte ? cur_ff.addr_byte : 8'd0;
   assign rsp_status    = cur_ff.has_byte ? 2'd0 : cur_ff.status;
   assign rsp_atype     = cur_ff.has_byte ? 2'd0 : cur_ff.atype;
   assign rsp_dlen      = cur_ff.has_byte ? 8'd0 : cur_ff.dlen;
   assign rsp_port      = cur_ff.has_byte ? 16'd0 : cur_ff.port;
   assign rsp_hlen      = cur_ff.has_byte ? 9'd0 : cur_ff.hlen;
   assign rsp_last      = !(cur_ff.has_byte && cur_ff.has_summary);

   a_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.has_byte || cur_ff.has_summary))
      else $error("held entry owes no transaction");

endmodule
